@@ rtl/core/hiwa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hiwa_pkg: shared types and constants
// Coefficient set, divider pipe word and register indexes of the inverse
// homography warp address generator.
// ----------------------------------------------------------------------------
package hiwa_pkg;

  localparam int CoefW = 48;
  localparam int CfgIdxW = 3;
  localparam int QW = 12;   // quotient bits, covers source sizes up to 4096
  localparam int NW = 66;   // projected sums
  localparam int DW = 84;   // numerators and limits
  localparam int PW = 63;   // coefficient times coordinate

  localparam int DefDestRows = 2048;
  localparam int DefSrcRows = 640;
  localparam int DefSrcCols = 480;

  localparam logic [CfgIdxW-1:0] CfgXx = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgXy = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgXt = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgYx = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgYy = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgYt = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgWx = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgWy = 3'd7;

  localparam logic signed [CoefW-1:0] CoefOne = 48'sh0001_0000_0000;
  localparam logic signed [CoefW-1:0] CoefZero = '0;

  typedef struct packed {
    logic signed [CoefW-1:0] xx;
    logic signed [CoefW-1:0] xy;
    logic signed [CoefW-1:0] xt;
    logic signed [CoefW-1:0] yx;
    logic signed [CoefW-1:0] yy;
    logic signed [CoefW-1:0] yt;
    logic signed [CoefW-1:0] wx;
    logic signed [CoefW-1:0] wy;
  } coef_t;

  typedef struct packed {
    logic          ok;
    logic [DW-1:0] d;
    logic [DW-1:0] nc;
    logic [DW-1:0] nr;
    logic [QW-1:0] qc;
    logic [QW-1:0] qr;
  } div_t;

endpackage
`default_nettype wire

@@ rtl/core/hiwa_proj.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hiwa_proj: projective transform front end
// Six stages: coordinates, products, sums, sign fold of w, numerators and
// limits, range check. Delivers numerators and divisor for the divider.
// ----------------------------------------------------------------------------
module hiwa_proj import hiwa_pkg::*; #(
  parameter int DEST_ROWS = DefDestRows,
  parameter int SRC_ROWS  = DefSrcRows,
  parameter int SRC_COLS  = DefSrcCols
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [10:0] dest_row_i,
  input  wire logic [10:0] dest_col_i,
  input  wire coef_t       coef_i,
  output logic             valid_o,
  output div_t             word_o
);

  localparam int Y2Base = 2 * DEST_ROWS - 1;
  localparam int RowMul = 2 * SRC_ROWS - 1;
  localparam int ColLim = 2 * SRC_COLS;
  localparam int RowLim = 2 * SRC_ROWS;
  localparam logic signed [NW-1:0] WOne = $signed({{(NW-34){1'b0}}, 1'b1, 33'b0});

  logic [5:0] v_q;

  // stage 1
  logic signed [14:0] x2_d, x2_q, y2_d, y2_q;
  // stage 2
  logic signed [PW-1:0] pxx_q, pxy_q, pyx_q, pyy_q, pwx_q, pwy_q;
  // stage 3
  logic signed [NW-1:0] nx_d, ny_d, w_d, nx_q, ny_q, w_q;
  // stage 4
  logic signed [NW-1:0] nxa_q, nya_q, wa_q;
  logic                 nz4_q;
  // stage 5
  logic signed [DW-1:0] nc_d, nr_d, d_d, lc_d, lr_d;
  logic signed [DW-1:0] nc_q, nr_q, d_q, lc_q, lr_q;
  logic                 nz5_q;
  // stage 6
  div_t word_d, word_q;

  assign x2_d = $signed({3'b0, dest_col_i, 1'b1});
  assign y2_d = $signed(15'(Y2Base)) - $signed({3'b0, dest_row_i, 1'b0});

  assign nx_d = NW'(pxx_q) + NW'(pxy_q) + (NW'(coef_i.xt) <<< 1);
  assign ny_d = NW'(pyx_q) + NW'(pyy_q) + (NW'(coef_i.yt) <<< 1);
  assign w_d  = NW'(pwx_q) + NW'(pwy_q) + WOne;

  assign nc_d = (DW'(nxa_q) <<< 1) - DW'(wa_q);
  assign nr_d = DW'(wa_q) * $signed(DW'(RowMul)) - (DW'(nya_q) <<< 1);
  assign d_d  = DW'(wa_q) <<< 1;
  assign lc_d = DW'(wa_q) * $signed(DW'(ColLim));
  assign lr_d = DW'(wa_q) * $signed(DW'(RowLim));

  always_comb begin
    word_d    = '0;
    word_d.ok = nz5_q && !nc_q[DW-1] && !nr_q[DW-1] && (nc_q < lc_q) && (nr_q < lr_q);
    word_d.d  = d_q;
    word_d.nc = nc_q;
    word_d.nr = nr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[4:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x2_q   <= x2_d;
      y2_q   <= y2_d;
      pxx_q  <= coef_i.xx * x2_q;
      pxy_q  <= coef_i.xy * y2_q;
      pyx_q  <= coef_i.yx * x2_q;
      pyy_q  <= coef_i.yy * y2_q;
      pwx_q  <= coef_i.wx * x2_q;
      pwy_q  <= coef_i.wy * y2_q;
      nx_q   <= nx_d;
      ny_q   <= ny_d;
      w_q    <= w_d;
      nxa_q  <= w_q[NW-1] ? -nx_q : nx_q;
      nya_q  <= w_q[NW-1] ? -ny_q : ny_q;
      wa_q   <= w_q[NW-1] ? -w_q : w_q;
      nz4_q  <= |w_q;
      nc_q   <= nc_d;
      nr_q   <= nr_d;
      d_q    <= d_d;
      lc_q   <= lc_d;
      lr_q   <= lr_d;
      nz5_q  <= nz4_q;
      word_q <= word_d;
    end
  end

  assign valid_o = v_q[5];
  assign word_o  = word_q;

endmodule
`default_nettype wire

@@ rtl/core/hiwa_div_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hiwa_div_stage: one restoring division step
// Resolves quotient bit BIT of both the column and the row quotient.
// ----------------------------------------------------------------------------
module hiwa_div_stage import hiwa_pkg::*; #(
  parameter int BIT = 0
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic valid_i,
  input  wire div_t word_i,
  output logic      valid_o,
  output div_t      word_o
);

  logic [DW-1:0] dsh;
  logic          ge_c, ge_r;
  div_t          word_d, word_q;
  logic          valid_q;

  assign dsh  = word_i.d << BIT;
  assign ge_c = word_i.nc >= dsh;
  assign ge_r = word_i.nr >= dsh;

  always_comb begin
    word_d         = word_i;
    word_d.nc      = ge_c ? word_i.nc - dsh : word_i.nc;
    word_d.nr      = ge_r ? word_i.nr - dsh : word_i.nr;
    word_d.qc[BIT] = ge_c;
    word_d.qr[BIT] = ge_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= word_d;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;

endmodule
`default_nettype wire

@@ rtl/core/homography_inverse_warp_address.sv @@
`timescale 1ns / 1ps
`default_nettype none
// An input word passes through the projection front end and then the divider stages before its output word is valid.
// Throughput: one word per cycle; the whole pipe advances together and holds
// while the output word is stalled.
// The divider resolves one quotient bit per stage over 12 stages.
// Reset: pipe emptied, coefficients return to the identity homography.
// ----------------------------------------------------------------------------
// homography_inverse_warp_address: top level
// Maps a destination canvas pixel through the inverse homography to a source
// address with an in-range flag.
// ----------------------------------------------------------------------------
module homography_inverse_warp_address import hiwa_pkg::*; #(
  parameter int DEST_ROWS = DefDestRows,
  parameter int SRC_ROWS  = DefSrcRows,
  parameter int SRC_COLS  = DefSrcCols
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CoefW-1:0]   cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [10:0]        dest_row_i,
  input  wire logic [10:0]        dest_col_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [9:0]              src_row_o,
  output logic [8:0]              src_col_o,
  output logic                    in_range_o
);

  coef_t coef_q;
  logic  en;
  logic  pv   [QW+1];
  div_t  pw   [QW+1];

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.xx <= CoefOne;
      coef_q.xy <= CoefZero;
      coef_q.xt <= CoefZero;
      coef_q.yx <= CoefZero;
      coef_q.yy <= CoefOne;
      coef_q.yt <= CoefZero;
      coef_q.wx <= CoefZero;
      coef_q.wy <= CoefZero;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgXx:   coef_q.xx <= $signed(cfg_wdata_i);
        CfgXy:   coef_q.xy <= $signed(cfg_wdata_i);
        CfgXt:   coef_q.xt <= $signed(cfg_wdata_i);
        CfgYx:   coef_q.yx <= $signed(cfg_wdata_i);
        CfgYy:   coef_q.yy <= $signed(cfg_wdata_i);
        CfgYt:   coef_q.yt <= $signed(cfg_wdata_i);
        CfgWx:   coef_q.wx <= $signed(cfg_wdata_i);
        CfgWy:   coef_q.wy <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  hiwa_proj #(
    .DEST_ROWS(DEST_ROWS),
    .SRC_ROWS (SRC_ROWS),
    .SRC_COLS (SRC_COLS)
  ) u_proj (
    .clk_i,
    .rst_ni,
    .en_i      (en),
    .valid_i   (in_valid_i),
    .dest_row_i,
    .dest_col_i,
    .coef_i    (coef_q),
    .valid_o   (pv[0]),
    .word_o    (pw[0])
  );

  for (genvar k = 0; k < QW; k++) begin : g_div
    hiwa_div_stage #(
      .BIT(QW - 1 - k)
    ) u_stage (
      .clk_i,
      .rst_ni,
      .en_i    (en),
      .valid_i (pv[k]),
      .word_i  (pw[k]),
      .valid_o (pv[k+1]),
      .word_o  (pw[k+1])
    );
  end

  assign out_valid_o = pv[QW];
  assign in_range_o  = pw[QW].ok;
  assign src_row_o   = pw[QW].ok ? pw[QW].qr[9:0] : '0;
  assign src_col_o   = pw[QW].ok ? pw[QW].qc[8:0] : '0;

endmodule
`default_nettype wire

@@ rtl/core/hiwa_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hiwa_checker: port level checks
// Watches the top level ports; attached by bind.
// ----------------------------------------------------------------------------
module hiwa_checker import hiwa_pkg::*; #(
  parameter int SRC_ROWS = DefSrcRows,
  parameter int SRC_COLS = DefSrcCols
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [9:0]  src_row_o,
  input wire logic [8:0]  src_col_o,
  input wire logic        in_range_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(src_row_o)
      && $stable(src_col_o) && $stable(in_range_o))
    else $error("output word changed while stalled");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall does not follow output stall");

  a_zero_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |-> src_row_o == '0 && src_col_o == '0)
    else $error("out-of-range word carries an address");

  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_range_o |-> 32'(src_row_o) < SRC_ROWS
      && 32'(src_col_o) < SRC_COLS)
    else $error("address beyond source size");

endmodule

bind homography_inverse_warp_address hiwa_checker #(
  .SRC_ROWS(SRC_ROWS),
  .SRC_COLS(SRC_COLS)
) u_hiwa_checker (.*);
`default_nettype wire
